/* sv/dcet_pkg.sv */
// ----------------------------------------------------------------------------
// dcet_pkg
// Shared beat types, operation codes, register offsets and bit positions of
// the down-counting event timer.
// ----------------------------------------------------------------------------
package dcet_pkg;

  // Operation codes of an input beat
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Register word offsets
  localparam logic [2:0] REG_LOAD_LO   = 3'd0;
  localparam logic [2:0] REG_LOAD_HI   = 3'd1;
  localparam logic [2:0] REG_VALUE_LO  = 3'd2;
  localparam logic [2:0] REG_VALUE_HI  = 3'd3;
  localparam logic [2:0] REG_CTL       = 3'd4;
  localparam logic [2:0] REG_INT       = 3'd5;
  localparam logic [2:0] REG_SHADOW_LO = 3'd6;
  localparam logic [2:0] REG_SHADOW_HI = 3'd7;

  // Control register bits
  localparam int CTL_PERIODIC_BIT = 0;
  localparam int CTL_ENABLE_BIT   = 1;
  localparam int CTL_WIDE_BIT     = 16;

  // Interrupt register bits
  localparam int INT_EN_BIT     = 0;
  localparam int INT_RAW_BIT    = 1;
  localparam int INT_MASKED_BIT = 2;
  localparam int INT_CLR_BIT    = 3;

  // Low word mask of the counter
  localparam logic [63:0] LO32_MASK = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_line;
  } out_beat_t;

endpackage

/* sv/dcet_core.sv */
// ----------------------------------------------------------------------------
// dcet_core
// Timer state and register file: applies one beat per enabled cycle and
// forms its result from the state the beat leaves.
// ----------------------------------------------------------------------------
module dcet_core #(
  parameter int COUNTER_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  dcet_pkg::in_beat_t item,
  output dcet_pkg::out_beat_t result
);

  localparam logic [COUNTER_BITS-1:0] LO_MASK = COUNTER_BITS'(dcet_pkg::LO32_MASK);
  localparam logic [COUNTER_BITS-1:0] ONE     = COUNTER_BITS'(1);

  logic [COUNTER_BITS-1:0] load_r, load_nxt;
  logic [COUNTER_BITS-1:0] count_r, count_nxt;
  logic                    run_r, run_nxt;
  logic                    periodic_r, periodic_nxt;
  logic                    wide_r, wide_nxt;
  logic                    irq_en_r, irq_en_nxt;
  logic                    irq_raw_r, irq_raw_nxt;

  logic [COUNTER_BITS-1:0] eff_mask;
  logic [COUNTER_BITS-1:0] ctl_mask;
  logic [COUNTER_BITS-1:0] eff_count;
  logic [COUNTER_BITS-1:0] eff_load;
  logic [63:0]             load_ext;
  logic [63:0]             count_ext;
  logic [31:0]             wd;
  logic [31:0]             rd;

  // Work out the next state and the read data of the current beat
  always_comb begin
    load_nxt     = load_r;
    count_nxt    = count_r;
    run_nxt      = run_r;
    periodic_nxt = periodic_r;
    wide_nxt     = wide_r;
    irq_en_nxt   = irq_en_r;
    irq_raw_nxt  = irq_raw_r;
    rd           = '0;
    wd           = item.write_data;

    eff_mask  = wide_r ? '1 : LO_MASK;
    ctl_mask  = wd[dcet_pkg::CTL_WIDE_BIT] ? '1 : LO_MASK;
    eff_count = count_r & eff_mask;
    eff_load  = load_r & eff_mask;
    load_ext  = 64'(load_r);
    count_ext = 64'(count_r);

    unique case (item.operation)
      dcet_pkg::OP_TICK: begin
        // Count down, then fire and reload or stop at zero
        if (run_r) begin
          if (eff_count <= ONE) begin
            irq_raw_nxt = 1'b1;
            if (periodic_r) begin
              count_nxt = eff_load;
            end else begin
              count_nxt = '0;
              run_nxt   = 1'b0;
            end
          end else begin
            count_nxt = eff_count - ONE;
          end
        end
      end
      dcet_pkg::OP_READ: begin
        unique case (item.reg_index)
          dcet_pkg::REG_LOAD_LO:   rd = load_ext[31:0];
          dcet_pkg::REG_LOAD_HI:   rd = load_ext[63:32];
          dcet_pkg::REG_VALUE_LO,
          dcet_pkg::REG_SHADOW_LO: rd = count_ext[31:0];
          dcet_pkg::REG_VALUE_HI,
          dcet_pkg::REG_SHADOW_HI: rd = count_ext[63:32];
          dcet_pkg::REG_CTL: begin
            rd[dcet_pkg::CTL_PERIODIC_BIT] = periodic_r;
            rd[dcet_pkg::CTL_ENABLE_BIT]   = run_r;
            rd[dcet_pkg::CTL_WIDE_BIT]     = wide_r;
          end
          dcet_pkg::REG_INT: begin
            rd[dcet_pkg::INT_EN_BIT]     = irq_en_r;
            rd[dcet_pkg::INT_RAW_BIT]    = irq_raw_r;
            rd[dcet_pkg::INT_MASKED_BIT] = irq_raw_r & irq_en_r;
          end
          default: rd = '0;
        endcase
      end
      dcet_pkg::OP_WRITE: begin
        unique case (item.reg_index)
          dcet_pkg::REG_LOAD_LO: load_nxt = COUNTER_BITS'({load_ext[63:32], wd});
          dcet_pkg::REG_LOAD_HI: load_nxt = COUNTER_BITS'({wd, load_ext[31:0]});
          dcet_pkg::REG_CTL: begin
            periodic_nxt = wd[dcet_pkg::CTL_PERIODIC_BIT];
            wide_nxt     = wd[dcet_pkg::CTL_WIDE_BIT];
            run_nxt      = wd[dcet_pkg::CTL_ENABLE_BIT];
            // Load the counter on a rising enable only
            if (wd[dcet_pkg::CTL_ENABLE_BIT] && !run_r) begin
              count_nxt = load_r & ctl_mask;
            end
          end
          dcet_pkg::REG_INT: begin
            irq_en_nxt = wd[dcet_pkg::INT_EN_BIT];
            if (wd[dcet_pkg::INT_CLR_BIT]) begin
              irq_raw_nxt = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    result.read_data = rd;
    result.irq_line  = irq_raw_nxt & irq_en_nxt;
  end

  // Advance the timer state on each processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r     <= '0;
      count_r    <= '0;
      run_r      <= 1'b0;
      periodic_r <= 1'b0;
      wide_r     <= 1'b0;
      irq_en_r   <= 1'b0;
      irq_raw_r  <= 1'b0;
    end else if (step_en) begin
      load_r     <= load_nxt;
      count_r    <= count_nxt;
      run_r      <= run_nxt;
      periodic_r <= periodic_nxt;
      wide_r     <= wide_nxt;
      irq_en_r   <= irq_en_nxt;
      irq_raw_r  <= irq_raw_nxt;
    end
  end

endmodule

/* sv/down_counting_event_timer_unit.sv */
// ----------------------------------------------------------------------------
// down_counting_event_timer_unit
// Down-counting timer with load, value, control, interrupt and shadow
// registers; each tick, read or write beat yields one result beat.
// ----------------------------------------------------------------------------
// Path: input accept to out_valid passes the input register, then the state
//   update and result register.
// Throughput: one beat per cycle unless out_stall holds a full result register;
//   the single-pass update of the timer state follows the input register.
// Reset: rst_n clears both valid stages and all timer state to zero.
module down_counting_event_timer_unit #(
  parameter int COUNTER_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dcet_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dcet_pkg::out_beat_t  out_data
);

  logic                s1_valid_r, s1_valid_nxt;
  dcet_pkg::in_beat_t  s1_item_r;
  logic                out_valid_r, out_valid_nxt;
  dcet_pkg::out_beat_t out_data_r;
  dcet_pkg::out_beat_t core_result;
  logic                out_free;
  logic                step_en;
  logic                in_accept;

  // Handshake: process a held beat whenever the result register can take it
  assign out_free      = !out_valid_r || !out_stall;
  assign step_en       = s1_valid_r && out_free;
  assign in_stall      = s1_valid_r && !out_free;
  assign in_accept     = in_valid && !in_stall;
  assign s1_valid_nxt  = in_accept || (s1_valid_r && !step_en);
  assign out_valid_nxt = step_en || (out_valid_r && out_stall);

  dcet_core #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(step_en),
    .item   (s1_item_r),
    .result (core_result)
  );

  // Hold valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture input and result payloads
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
    end
    if (step_en) begin
      out_data_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the down-counting event timer. Every input beat
// (tick, register read or register write) is applied to a timer model kept
// here, and each result beat from the unit is compared with the model's
// readback and interrupt line, in order. Directed register, one-shot and
// periodic checks are followed by random traffic under several idle and
// stall mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int CNT_BITS = 64;
  localparam logic [63:0] FULL_MASK = (CNT_BITS == 64) ? 64'hFFFF_FFFF_FFFF_FFFF :
                                      ((64'd1 << CNT_BITS) - 64'd1);
  localparam logic [31:0] CTL_PERIODIC = 32'd1 << dcet_pkg::CTL_PERIODIC_BIT;
  localparam logic [31:0] CTL_RUN      = 32'd1 << dcet_pkg::CTL_ENABLE_BIT;
  localparam logic [31:0] CTL_WIDE     = 32'd1 << dcet_pkg::CTL_WIDE_BIT;
  localparam logic [31:0] INT_EN       = 32'd1 << dcet_pkg::INT_EN_BIT;
  localparam logic [31:0] INT_CLR      = 32'd1 << dcet_pkg::INT_CLR_BIT;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  dcet_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  dcet_pkg::out_beat_t out_data;

  // Sender idle and receiver stall rates, percent
  int send_idle_pct = 0;
  int stall_pct = 0;
  int err_count = 0;

  // Long hold-off request, counted out by the stall process
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  // Timer model state
  logic [63:0] tm_load = '0;
  logic [63:0] tm_count = '0;
  logic        tm_run = 1'b0;
  logic        tm_periodic = 1'b0;
  logic        tm_wide = 1'b0;
  logic        tm_irq_en = 1'b0;
  logic        tm_irq_raw = 1'b0;

  dcet_pkg::out_beat_t timer_result_q[$];

  down_counting_event_timer_unit #(
    .COUNTER_BITS(CNT_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one beat to the timer model and return its result
  function automatic dcet_pkg::out_beat_t advance_timer(input dcet_pkg::in_beat_t b);
    dcet_pkg::out_beat_t r;
    logic [63:0]         width_mask;
    logic [63:0]         cur;
    logic                was_running;
    r = '0;
    width_mask = tm_wide ? FULL_MASK : dcet_pkg::LO32_MASK;
    unique case (b.operation)
      dcet_pkg::OP_TICK: begin
        if (tm_run) begin
          cur = tm_count & width_mask;
          if (cur <= 64'd1) begin
            tm_irq_raw = 1'b1;
            if (tm_periodic) begin
              tm_count = tm_load & width_mask;
            end else begin
              tm_count = '0;
              tm_run = 1'b0;
            end
          end else begin
            tm_count = cur - 64'd1;
          end
        end
      end
      dcet_pkg::OP_READ: begin
        unique case (b.reg_index)
          dcet_pkg::REG_LOAD_LO: r.read_data = tm_load[31:0];
          dcet_pkg::REG_LOAD_HI: r.read_data = 32'((tm_load & FULL_MASK) >> 32);
          dcet_pkg::REG_VALUE_LO, dcet_pkg::REG_SHADOW_LO: r.read_data = tm_count[31:0];
          dcet_pkg::REG_VALUE_HI, dcet_pkg::REG_SHADOW_HI: begin
            r.read_data = 32'((tm_count & FULL_MASK) >> 32);
          end
          dcet_pkg::REG_CTL: begin
            r.read_data[dcet_pkg::CTL_PERIODIC_BIT] = tm_periodic;
            r.read_data[dcet_pkg::CTL_ENABLE_BIT] = tm_run;
            r.read_data[dcet_pkg::CTL_WIDE_BIT] = tm_wide;
          end
          dcet_pkg::REG_INT: begin
            r.read_data[dcet_pkg::INT_EN_BIT] = tm_irq_en;
            r.read_data[dcet_pkg::INT_RAW_BIT] = tm_irq_raw;
            r.read_data[dcet_pkg::INT_MASKED_BIT] = tm_irq_raw & tm_irq_en;
          end
          default: ;
        endcase
      end
      dcet_pkg::OP_WRITE: begin
        unique case (b.reg_index)
          dcet_pkg::REG_LOAD_LO: tm_load[31:0] = b.write_data;
          dcet_pkg::REG_LOAD_HI: tm_load = {b.write_data, tm_load[31:0]} & FULL_MASK;
          dcet_pkg::REG_CTL: begin
            was_running = tm_run;
            tm_periodic = b.write_data[dcet_pkg::CTL_PERIODIC_BIT];
            tm_wide = b.write_data[dcet_pkg::CTL_WIDE_BIT];
            tm_run = b.write_data[dcet_pkg::CTL_ENABLE_BIT];
            // Reload only on the rising edge of enable, at the new width
            if (tm_run && !was_running) begin
              tm_count = tm_load & (tm_wide ? FULL_MASK : dcet_pkg::LO32_MASK);
            end
          end
          dcet_pkg::REG_INT: begin
            tm_irq_en = b.write_data[dcet_pkg::INT_EN_BIT];
            if (b.write_data[dcet_pkg::INT_CLR_BIT]) begin
              tm_irq_raw = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.irq_line = tm_irq_raw & tm_irq_en;
    return r;
  endfunction

  function automatic dcet_pkg::in_beat_t timer_beat(input logic [1:0] op,
                                                    input logic [2:0] idx,
                                                    input logic [31:0] data);
    dcet_pkg::in_beat_t b;
    b.operation = op;
    b.reg_index = idx;
    b.write_data = data;
    return b;
  endfunction

  // Mostly well-formed traffic: short loads, control and interrupt writes
  function automatic dcet_pkg::in_beat_t random_timer_beat();
    dcet_pkg::in_beat_t b;
    int                 pick;
    pick = $urandom_range(99);
    b.write_data = $urandom;
    b.reg_index = 3'($urandom_range(7));
    if (pick < 45) begin
      b.operation = dcet_pkg::OP_TICK;
    end else if (pick < 70) begin
      b.operation = dcet_pkg::OP_READ;
    end else if (pick < 98) begin
      b.operation = dcet_pkg::OP_WRITE;
      if ($urandom_range(9) < 3) begin
        b.reg_index = dcet_pkg::REG_CTL;
      end
      unique case (b.reg_index)
        dcet_pkg::REG_LOAD_LO: if ($urandom_range(9) < 7) b.write_data = $urandom_range(12);
        dcet_pkg::REG_LOAD_HI: if ($urandom_range(9) < 7) b.write_data = '0;
        dcet_pkg::REG_CTL: if ($urandom_range(3) != 0) begin
          b.write_data &= CTL_PERIODIC | CTL_RUN | CTL_WIDE;
        end
        dcet_pkg::REG_INT: if ($urandom_range(3) != 0) b.write_data &= INT_EN | INT_CLR;
        default: ;
      endcase
    end else begin
      b.operation = dcet_pkg::OP_NONE;
    end
    return b;
  endfunction

  // Offer one beat, idling first at the current rate; predict on accept
  task automatic send_beat(input dcet_pkg::in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    timer_result_q.push_back(advance_timer(b));
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    send_beat(timer_beat(dcet_pkg::OP_WRITE, idx, data));
  endtask

  task automatic reg_read(input logic [2:0] idx);
    send_beat(timer_beat(dcet_pkg::OP_READ, idx, '0));
  endtask

  task automatic tick_once();
    send_beat(timer_beat(dcet_pkg::OP_TICK, '0, $urandom));
  endtask

  // Drop valid and let every predicted result arrive
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (timer_result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_register_access();
    reg_write(dcet_pkg::REG_LOAD_LO, 32'hFFFF_FFFF);
    reg_write(dcet_pkg::REG_LOAD_HI, 32'hFFFF_FFFF);
    reg_read(dcet_pkg::REG_LOAD_HI);
    // Value and shadow registers are read only
    reg_write(dcet_pkg::REG_VALUE_LO, 32'h1234_5678);
    reg_write(dcet_pkg::REG_SHADOW_HI, 32'hFFFF_FFFF);
    reg_read(dcet_pkg::REG_SHADOW_LO);
    send_beat(timer_beat(dcet_pkg::OP_NONE, dcet_pkg::REG_CTL, 32'hFFFF_FFFF));
    // All control bits set: enable loads the full 64-bit count
    reg_write(dcet_pkg::REG_CTL, 32'hFFFF_FFFF);
    reg_read(dcet_pkg::REG_VALUE_HI);
    reg_write(dcet_pkg::REG_CTL, 32'h0000_0000);
    reg_write(dcet_pkg::REG_INT, 32'hFFFF_FFFF);
    reg_read(dcet_pkg::REG_INT);
    finish_phase();
  endtask

  task automatic test_one_shot();
    // Narrow mode ignores the high load word
    reg_write(dcet_pkg::REG_LOAD_LO, 32'd2);
    reg_write(dcet_pkg::REG_CTL, CTL_RUN);
    tick_once();
    tick_once();
    tick_once();
    reg_read(dcet_pkg::REG_CTL);
    reg_write(dcet_pkg::REG_INT, INT_EN | INT_CLR);
    finish_phase();
  endtask

  task automatic test_periodic_wide();
    reg_write(dcet_pkg::REG_LOAD_HI, 32'd0);
    reg_write(dcet_pkg::REG_LOAD_LO, 32'd0);
    reg_write(dcet_pkg::REG_CTL, CTL_PERIODIC | CTL_RUN | CTL_WIDE);
    tick_once();
    // Rewriting enable while running must not reload
    reg_write(dcet_pkg::REG_LOAD_LO, 32'd5);
    reg_write(dcet_pkg::REG_CTL, CTL_PERIODIC | CTL_RUN | CTL_WIDE);
    tick_once();
    reg_read(dcet_pkg::REG_VALUE_LO);
    finish_phase();
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_rate);
    send_idle_pct = idle_pct;
    stall_pct = stall_rate;
    for (int i = 0; i < count; i++) begin
      send_beat(random_timer_beat());
    end
    finish_phase();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req <= ~hold_req;
    for (int i = 0; i < 50; i++) begin
      send_beat(random_timer_beat());
    end
    finish_phase();
  endtask

  // Receiver stall, with a counted long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each accepted result beat with the oldest prediction
  always @(posedge clk) begin
    dcet_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (timer_result_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual read_data=%h irq_line=%b",
                 $time, out_data.read_data, out_data.irq_line);
        err_count++;
      end else begin
        want = timer_result_q.pop_front();
        if (out_data.read_data !== want.read_data) begin
          $display("%0t: read_data mismatch: expected %h, actual %h",
                   $time, want.read_data, out_data.read_data);
          err_count++;
        end
        if (out_data.irq_line !== want.irq_line) begin
          $display("%0t: irq_line mismatch: expected %b, actual %b",
                   $time, want.irq_line, out_data.irq_line);
          err_count++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_one_shot();
    test_periodic_wide();
    test_random_traffic(150, 0, 0);
    test_random_traffic(150, 77, 0);
    test_random_traffic(150, 0, 77);
    test_random_traffic(150, 36, 36);
    test_backpressure();
    if (err_count == 0) begin
      $display("down_counting_event_timer_unit regression: pass");
    end else begin
      $display("down_counting_event_timer_unit regression: fail");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #5000000;
    $display("down_counting_event_timer_unit regression: fail");
    $finish;
  end

endmodule
